[design/bfa_pkg.sv]
package bfa_pkg;
    localparam int MAX_FRAMES_DEF = 4096;
    localparam int WORD_BITS = 64;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_MARK  = 2'd2;
    localparam logic [1:0] ACT_RSVD  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [12:0] frame_count;
        logic [12:0] align_frames;
        logic [11:0] start_frame;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [11:0] base_frame;
    } t_rsp;
endpackage

[design/bfa_ram.sv]
module bfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[design/bitmap_frame_allocator_unit.sv]
// After reset a clearing pass writes zero to every bitmap word before the first item is taken.
// Free and mark read each touched 64-frame word, then modify it and write it back.
// Allocate tests one frame per cycle, pausing for a read at the start of each 64-frame word;
// a used frame advances the base one alignment step per cycle until it passes that frame.
// Each word of the run is then read and written back. One item is in work at a time.
// Reset is synchronous; the frame limit returns to 4096 and the bitmap is cleared.
module bitmap_frame_allocator_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bfa_pkg::t_req i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output bfa_pkg::t_rsp o_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [12:0]   i_cfg_data
);
    import bfa_pkg::*;

    localparam int MAX_FRAMES = MAX_FRAMES_DEF;
    localparam int WORDS = MAX_FRAMES / WORD_BITS;
    localparam int AW = $clog2(WORDS);
    // Wide enough for a base plus the largest alignment step or count.
    localparam int FW = $clog2(MAX_FRAMES) + 2;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SRD   = 3'd2;  // scan: read issued
    localparam logic [2:0] ST_SCHK  = 3'd3;  // scan: test frame
    localparam logic [2:0] ST_WRD   = 3'd4;  // run write: read issued
    localparam logic [2:0] ST_WWR   = 3'd5;  // run write: modify and write back
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]  r_state;
    logic [12:0] r_avail;
    t_req        r_req;
    logic [FW-1:0] r_limit, r_step, r_base, r_f, r_end;
    logic        r_set, r_ok;
    logic [AW-1:0] r_clr;
    t_rsp        r_out;
    logic        r_ovalid;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata, rdata;

    bfa_ram #(.WIDTH(WORD_BITS), .DEPTH(WORDS)) u_map (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic [FW-1:0] cnt_w, step_w, lim_w, nxt_base, wend, mlo_end;
    logic [5:0] lo, hi;
    logic [63:0] mask;

    assign o_ready     = (r_state == ST_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_ovalid;
    assign o_data      = r_out;

    assign lim_w  = (r_avail > 13'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(r_avail);
    assign cnt_w  = FW'(i_data.frame_count);
    assign step_w = (i_data.align_frames == '0) ? FW'(1) : FW'(i_data.align_frames);

    // Next aligned base above frame r_f: base + step while the base does not pass r_f.
    // A used frame at r_f lies in [r_base, r_base+count), so we step base until > r_f
    // one step per cycle through r_base itself in ST_SCHK.
    assign nxt_base = r_base + r_step;

    // Word-level run write window.
    assign wend   = ({r_f[FW-1:6], 6'd0} + FW'(64) < r_end)
                  ? ({r_f[FW-1:6], 6'd0} + FW'(64)) : r_end;
    assign mlo_end = wend - FW'(1);
    assign lo = r_f[5:0];
    assign hi = mlo_end[5:0];
    always_comb begin
        for (int b = 0; b < 64; b++) begin
            mask[b] = (6'(b) >= lo) && (6'(b) <= hi);
        end
    end

    always_comb begin
        we = 1'b0;
        waddr = r_f[AW+5:6];
        wdata = r_set ? (rdata | mask) : (rdata & ~mask);
        raddr = r_f[AW+5:6];
        if (r_state == ST_CLEAR) begin
            we = 1'b1;
            waddr = r_clr;
            wdata = '0;
        end else if (r_state == ST_WWR) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_avail  <= 13'd4096;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_avail <= i_cfg_data;
            end
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(WORDS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req   <= i_data;
                        r_limit <= lim_w;
                        r_step  <= step_w;
                        r_base  <= '0;
                        r_f     <= '0;
                        r_ok    <= 1'b0;
                        if (i_data.action == ACT_ALLOC) begin
                            r_set <= 1'b1;
                            if (cnt_w == '0 || cnt_w > lim_w) begin
                                r_state <= ST_OUT;
                            end else begin
                                r_end   <= cnt_w;
                                r_state <= ST_SRD;
                            end
                        end else if (i_data.action == ACT_FREE
                                     || i_data.action == ACT_MARK) begin
                            r_ok  <= 1'b1;
                            r_set <= (i_data.action == ACT_MARK);
                            r_f   <= FW'(i_data.start_frame);
                            r_end <= (FW'(i_data.start_frame) + cnt_w > lim_w)
                                   ? lim_w : FW'(i_data.start_frame) + cnt_w;
                            if (cnt_w == '0 || FW'(i_data.start_frame) >= lim_w) begin
                                r_state <= ST_OUT;
                            end else begin
                                r_state <= ST_WRD;
                            end
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_SRD: begin
                    r_state <= ST_SCHK;
                end
                ST_SCHK: begin
                    if (rdata[r_f[5:0]]) begin
                        r_base <= nxt_base;
                        if (nxt_base > r_f) begin
                            if (nxt_base + FW'(r_req.frame_count) > r_limit
                                || nxt_base < r_base) begin
                                r_state <= ST_OUT;
                            end else begin
                                r_f   <= nxt_base;
                                r_end <= nxt_base + FW'(r_req.frame_count);
                                r_state <= ST_SRD;
                            end
                        end
                    end else if (r_f + FW'(1) == r_end) begin
                        r_f     <= r_base;
                        r_ok    <= 1'b1;
                        r_state <= ST_WRD;
                    end else begin
                        r_f <= r_f + FW'(1);
                        if (r_f[5:0] == 6'd63) begin
                            r_state <= ST_SRD;
                        end
                    end
                end
                ST_WRD: begin
                    r_state <= ST_WWR;
                end
                ST_WWR: begin
                    if (wend >= r_end) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_f <= wend;
                        r_state <= ST_WRD;
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid) begin
                        r_out.ok <= r_ok;
                        r_out.base_frame <= (r_ok && r_req.action == ACT_ALLOC)
                                          ? r_base[11:0] : 12'd0;
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("accept while busy");
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_valid)
        else $error("result during clear");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.ok) |-> (o_data.base_frame == 12'd0))
        else $error("failed result with nonzero base");
endmodule

[verif/bitmap_frame_allocator_unit_tb.sv]
module bitmap_frame_allocator_unit_tb;
    import bfa_pkg::*;

    class frame_map_scoreboard;
        bit [4095:0] used_map;
        int unsigned limit;
        t_rsp        expected_q[$];
        int          errors;

        function new();
            used_map = '0;
            limit = 4096;
            errors = 0;
        endfunction

        function void set_frames_available(logic [12:0] value);
            limit = (value > 4096) ? 4096 : value;
        endfunction

        function void write_run(int unsigned start, int unsigned count, bit used);
            for (int unsigned i = 0; i < count; i++) begin
                if (start + i >= limit) break;
                used_map[start + i] = used;
            end
        endfunction

        // Lowest aligned base with count free frames, jumping past each used frame.
        function bit allocate_run(int unsigned count, int unsigned step,
                                  output int unsigned base);
            int unsigned probe;
            bit blocked;
            base = 0;
            if (count == 0) return 0;
            while (base + count <= limit) begin
                blocked = 0;
                for (int unsigned i = 0; i < count; i++) begin
                    probe = base + i;
                    if (used_map[probe]) begin
                        base = (probe / step + 1) * step;
                        blocked = 1;
                        break;
                    end
                end
                if (!blocked) begin
                    for (int unsigned i = 0; i < count; i++) used_map[base + i] = 1'b1;
                    return 1;
                end
            end
            return 0;
        endfunction

        function void note_request(t_req req);
            t_rsp rsp;
            int unsigned base;
            rsp = '0;
            case (req.action)
                ACT_ALLOC: begin
                    rsp.ok = allocate_run(req.frame_count,
                                          (req.align_frames == 0) ? 1 : req.align_frames,
                                          base);
                    rsp.base_frame = rsp.ok ? base[11:0] : 12'd0;
                end
                ACT_FREE: begin
                    write_run(req.start_frame, req.frame_count, 1'b0);
                    rsp.ok = 1'b1;
                end
                ACT_MARK: begin
                    write_run(req.start_frame, req.frame_count, 1'b1);
                    rsp.ok = 1'b1;
                end
                default: ;
            endcase
            expected_q.push_back(rsp);
        endfunction

        function void check_response(t_rsp rsp);
            t_rsp exp_rsp;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result ok=%0b base=%0d", $time, rsp.ok,
                         rsp.base_frame);
                errors++;
                return;
            end
            exp_rsp = expected_q.pop_front();
            if (rsp.ok !== exp_rsp.ok) begin
                $display("%0t: ok mismatch, expected %0b actual %0b", $time, exp_rsp.ok,
                         rsp.ok);
                errors++;
            end
            if (rsp.base_frame !== exp_rsp.base_frame) begin
                $display("%0t: base_frame mismatch, expected %0d actual %0d", $time,
                         exp_rsp.base_frame, rsp.base_frame);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_req        i_data;
    logic        o_valid;
    logic        i_ready;
    t_rsp        o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [12:0] i_cfg_data;

    frame_map_scoreboard sb;
    bit quiet_mode;
    int stall_left;

    bitmap_frame_allocator_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data(o_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 30000000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) sb.note_request(i_data);
        if (i_rst_n && o_valid && i_ready) sb.check_response(o_data);
    end

    // Result side backpressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    task automatic send_request(t_req req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= req;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_op(logic [1:0] act, int count, int align, int start);
        t_req req;
        req.action = act;
        req.frame_count = count[12:0];
        req.align_frames = align[12:0];
        req.start_frame = start[11:0];
        send_request(req);
    endtask

    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_frames_available(logic [12:0] value);
        wait_results_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_frames_available(value);
    endtask

    function automatic t_req random_request();
        t_req req;
        int r;
        r = $urandom_range(0, 99);
        req.action = (r < 45) ? ACT_ALLOC : (r < 78) ? ACT_FREE : (r < 95) ? ACT_MARK
                   : ACT_RSVD;
        r = $urandom_range(0, 99);
        if (r < 80) req.frame_count = 13'($urandom_range(0, 16));
        else if (r < 95) req.frame_count = 13'($urandom_range(17, 300));
        else req.frame_count = 13'($urandom_range(0, 8191));
        r = $urandom_range(0, 99);
        if (r < 30) req.align_frames = 13'd0;
        else if (r < 85) req.align_frames = 13'd1 << $urandom_range(0, 6);
        else req.align_frames = 13'($urandom_range(0, 8191));
        req.start_frame = 12'($urandom_range(0, 4095));
        return req;
    endfunction

    initial begin
        logic [12:0] limits[6];
        sb = new();
        quiet_mode = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        stall_left = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_frames_available(13'd4096);
        send_op(ACT_ALLOC, 0, 0, 0);
        send_op(ACT_ALLOC, 1, 0, 0);
        send_op(ACT_ALLOC, 4096, 0, 0);
        send_op(ACT_FREE, 1, 0, 0);
        send_op(ACT_ALLOC, 4096, 0, 0);
        send_op(ACT_ALLOC, 1, 1, 0);
        send_op(ACT_FREE, 4096, 0, 0);
        send_op(ACT_MARK, 8191, 0, 4095);
        send_op(ACT_ALLOC, 8191, 8191, 4095);
        send_op(ACT_ALLOC, 1, 8191, 0);
        send_op(ACT_ALLOC, 1, 4096, 0);
        send_op(ACT_MARK, 64, 0, 100);
        send_op(ACT_ALLOC, 64, 64, 0);
        send_op(ACT_ALLOC, 3, 7, 0);
        send_op(ACT_RSVD, 5, 1, 10);
        send_op(ACT_FREE, 0, 0, 64);
        send_op(ACT_MARK, 0, 0, 64);
        send_op(ACT_FREE, 4096, 0, 0);

        limits[0] = 13'd8191;
        limits[1] = 13'd1;
        limits[2] = 13'd0;
        limits[3] = 13'd100;
        limits[4] = 13'd4097;
        limits[5] = 13'($urandom_range(1, 4096));
        foreach (limits[p]) begin
            write_frames_available(limits[p]);
            quiet_mode = (p == 3);
            send_op(ACT_FREE, 4096, 0, 0);
            for (int n = 0; n < 120; n++) begin
                // In the first phase only, hold off new requests once mid-phase until all results are back.
                if (n == 60 && p == 0) wait_results_drained();
                send_request(random_request());
            end
            quiet_mode = 1'b0;
        end
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

[files.f]
design/bfa_pkg.sv
design/bfa_ram.sv
design/bitmap_frame_allocator_unit.sv
verif/bitmap_frame_allocator_unit_tb.sv
